@@ src/barotc_pkg.sv @@
package barotc_pkg;

   // pipeline depth from input handshake to output register
   localparam int NUM_STAGES = 9;

   // configuration register indexes
   typedef enum logic [2:0] {
      CSR_SENS_COEF   = 3'd0,
      CSR_OFF_COEF    = 3'd1,
      CSR_TCS_COEF    = 3'd2,
      CSR_TCO_COEF    = 3'd3,
      CSR_TREF_COEF   = 3'd4,
      CSR_TSLOPE_COEF = 3'd5
   } csr_index_type;

   // 20.00 C as the base of the temperature, and 20.00 - (-15.00) C
   localparam logic signed [18:0] TEMP_BASE   = 19'sd2000;
   localparam logic signed [18:0] COLD_OFFSET = 19'sd3500;

   localparam logic [14:0] TEMP_OUT_MIN = 15'h4000;   // -16384
   localparam logic [14:0] TEMP_OUT_MAX = 15'h3FFF;   //  16383
   localparam logic [17:0] PRES_OUT_MAX = 18'h3FFFF;  // 262143

endpackage

@@ src/barometer_temperature_compensation_top.sv @@
// Second-order temperature compensation for a 24-bit barometric sensor.
// req_ channel: one item holds a raw pressure and a raw temperature
// conversion. rsp_ channel: one item per input item, in order, holding the
// compensated temperature (0.01 C, signed) and pressure (Pa); rsp_tuser is
// high when either value was clipped to its output range.
// csr_ port: the six 16-bit calibration words, written by index; the user
// must write them only while the block is idle, which the block itself does
// not enforce. Indexes above five are ignored. One item is taken in every
// cycle while the receiver does not stall. The depth is set by the chain
// dT -> products with dT -> first-order terms and squares -> second-order
// terms -> corrected terms -> 24x41 pressure multiply (split in two halves)
// -> shift and subtract -> final shift and clip.
// Each stage moves on when the stage after it is empty or moving, so a
// stalled receiver holds the output register and bubbles inside the
// pipeline still fill up; req_tready drops only when all stages are full.
// Reset (synchronous) empties the pipeline and clears the calibration
// words to zero.
module barometer_temperature_compensation_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // pressure_raw[23:0], temperature_raw[47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // temperature_centi[14:0], pressure_pa[32:15], zero pad
   output logic [0:0]  rsp_tuser,   // range_flag[0]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int N = barotc_pkg::NUM_STAGES;

   // calibration words
   logic [15:0] c1_ff, c2_ff, c3_ff, c4_ff, c5_ff, c6_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c1_ff <= '0;
         c2_ff <= '0;
         c3_ff <= '0;
         c4_ff <= '0;
         c5_ff <= '0;
         c6_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            barotc_pkg::CSR_SENS_COEF:   c1_ff <= csr_wdata;
            barotc_pkg::CSR_OFF_COEF:    c2_ff <= csr_wdata;
            barotc_pkg::CSR_TCS_COEF:    c3_ff <= csr_wdata;
            barotc_pkg::CSR_TCO_COEF:    c4_ff <= csr_wdata;
            barotc_pkg::CSR_TREF_COEF:   c5_ff <= csr_wdata;
            barotc_pkg::CSR_TSLOPE_COEF: c6_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // valid bits and per-stage advance
   logic [N-1:0] vld_ff, vld_in, en;

   always_comb begin
      en[N-1] = !vld_ff[N-1] || rsp_tready;
      for (int k = N - 2; k >= 0; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in = {vld_ff[N-2:0], req_tvalid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int k = 0; k < N; k++) begin
            if (en[k]) begin
               vld_ff[k] <= vld_in[k];
            end
         end
      end
   end

   assign req_tready = en[0];
   assign rsp_tvalid = vld_ff[N-1];

   // stage 1: dT
   logic [23:0]        d1_s1_ff;
   logic signed [24:0] dt_ff, dt_in;

   assign dt_in = $signed({1'b0, req_tdata[47:24]}) - $signed({1'b0, c5_ff, 8'd0});

   always_ff @(posedge clock) begin
      if (en[0]) begin
         d1_s1_ff <= req_tdata[23:0];
         dt_ff    <= dt_in;
      end
   end

   // stage 2: products with dT
   logic [23:0]        d1_s2_ff;
   logic signed [40:0] dtc6_ff, dtc6_in, c4dt_ff, c4dt_in, c3dt_ff, c3dt_in;
   logic signed [49:0] dtsq_full;
   logic [47:0]        dtsq_ff;

   assign dtc6_in   = dt_ff * $signed({1'b0, c6_ff});
   assign c4dt_in   = dt_ff * $signed({1'b0, c4_ff});
   assign c3dt_in   = dt_ff * $signed({1'b0, c3_ff});
   assign dtsq_full = dt_ff * dt_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         d1_s2_ff <= d1_s1_ff;
         dtc6_ff  <= dtc6_in;
         c4dt_ff  <= c4dt_in;
         c3dt_ff  <= c3dt_in;
         dtsq_ff  <= dtsq_full[47:0];
      end
   end

   // stage 3: first-order TEMP, OFF, SENS; squares for the correction
   logic signed [17:0] tdelta;     // TEMP - 2000
   logic signed [18:0] cold_dist;  // TEMP + 1500
   logic signed [35:0] a_full;
   logic signed [37:0] b_full;
   logic [23:0]        d1_s3_ff;
   logic signed [18:0] temp_s3_ff, temp_in;
   logic signed [35:0] off_s3_ff, off_in;
   logic signed [34:0] sens_s3_ff, sens_in;
   logic [16:0]        t2_ff, t2_in;
   logic [34:0]        a_ff;
   logic [35:0]        b_ff;
   logic               low20_ff, low15_ff;

   assign tdelta    = dtc6_ff[40:23];
   assign cold_dist = $signed({tdelta[17], tdelta}) + barotc_pkg::COLD_OFFSET;
   assign temp_in   = $signed({tdelta[17], tdelta}) + barotc_pkg::TEMP_BASE;
   assign a_full    = tdelta * tdelta;
   assign b_full    = cold_dist * cold_dist;
   assign off_in    = $signed({4'd0, c2_ff, 16'd0})
                    + $signed({{2{c4dt_ff[40]}}, c4dt_ff[40:7]});
   assign sens_in   = $signed({4'd0, c1_ff, 15'd0})
                    + $signed({{2{c3dt_ff[40]}}, c3dt_ff[40:8]});
   assign t2_in     = dtsq_ff[47:31];

   always_ff @(posedge clock) begin
      if (en[2]) begin
         d1_s3_ff   <= d1_s2_ff;
         temp_s3_ff <= temp_in;
         off_s3_ff  <= off_in;
         sens_s3_ff <= sens_in;
         t2_ff      <= t2_in;
         a_ff       <= a_full[34:0];
         b_ff       <= b_full[35:0];
         low20_ff   <= tdelta[17];
         low15_ff   <= cold_dist[18];
      end
   end

   // stage 4: OFF2, SENS2, T2 gated by the temperature bands
   logic [36:0]        five_a;
   logic [38:0]        seven_b;
   logic [39:0]        eleven_b;
   logic [23:0]        d1_s4_ff;
   logic signed [18:0] temp_s4_ff;
   logic signed [35:0] off_s4_ff;
   logic signed [34:0] sens_s4_ff;
   logic [39:0]        off2_ff, off2_in, sens2_ff, sens2_in;
   logic [16:0]        t2g_ff, t2g_in;

   assign five_a   = {a_ff, 2'd0} + {2'd0, a_ff};
   assign seven_b  = {b_ff, 3'd0} - {3'd0, b_ff};
   assign eleven_b = {1'b0, b_ff, 3'd0} + {3'd0, b_ff, 1'b0} + {4'd0, b_ff};

   always_comb begin
      off2_in  = '0;
      sens2_in = '0;
      t2g_in   = '0;
      if (low20_ff) begin
         t2g_in   = t2_ff;
         off2_in  = {4'd0, five_a[36:1]} + (low15_ff ? {1'b0, seven_b} : 40'd0);
         sens2_in = {5'd0, five_a[36:2]} + (low15_ff ? {1'b0, eleven_b[39:1]} : 40'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         d1_s4_ff   <= d1_s3_ff;
         temp_s4_ff <= temp_s3_ff;
         off_s4_ff  <= off_s3_ff;
         sens_s4_ff <= sens_s3_ff;
         off2_ff    <= off2_in;
         sens2_ff   <= sens2_in;
         t2g_ff     <= t2g_in;
      end
   end

   // stage 5: corrected TEMP, OFF, SENS
   logic [23:0]        d1_s5_ff;
   logic signed [19:0] temp_c_s5_ff, temp_c_in;
   logic signed [40:0] off_c_s5_ff, off_c_in, sens_c_ff, sens_c_in;

   assign temp_c_in = $signed({temp_s4_ff[18], temp_s4_ff}) - $signed({3'd0, t2g_ff});
   assign off_c_in  = $signed({{5{off_s4_ff[35]}}, off_s4_ff}) - $signed({1'b0, off2_ff});
   assign sens_c_in = $signed({{6{sens_s4_ff[34]}}, sens_s4_ff}) - $signed({1'b0, sens2_ff});

   always_ff @(posedge clock) begin
      if (en[4]) begin
         d1_s5_ff     <= d1_s4_ff;
         temp_c_s5_ff <= temp_c_in;
         off_c_s5_ff  <= off_c_in;
         sens_c_ff    <= sens_c_in;
      end
   end

   // stage 6: D1 * SENS as two partial products
   logic [20:0]        sens_lo;
   logic signed [19:0] sens_hi;
   logic [44:0]        plo_ff, plo_in;
   logic signed [44:0] phi_ff, phi_in;
   logic signed [19:0] temp_c_s6_ff;
   logic signed [40:0] off_c_s6_ff;

   assign sens_lo = sens_c_ff[20:0];
   assign sens_hi = sens_c_ff[40:21];
   assign plo_in  = d1_s5_ff * sens_lo;
   assign phi_in  = $signed({1'b0, d1_s5_ff}) * sens_hi;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         plo_ff       <= plo_in;
         phi_ff       <= phi_in;
         temp_c_s6_ff <= temp_c_s5_ff;
         off_c_s6_ff  <= off_c_s5_ff;
      end
   end

   // stage 7: recombine the product
   logic signed [63:0] prod_ff, prod_in;
   logic signed [19:0] temp_c_s7_ff;
   logic signed [40:0] off_c_s7_ff;

   assign prod_in = $signed({phi_ff[42:0], 21'd0}) + $signed({19'd0, plo_ff});

   always_ff @(posedge clock) begin
      if (en[6]) begin
         prod_ff      <= prod_in;
         temp_c_s7_ff <= temp_c_s6_ff;
         off_c_s7_ff  <= off_c_s6_ff;
      end
   end

   // stage 8: (D1*SENS >> 21) - OFF
   logic signed [44:0] q_ff, q_in;
   logic signed [19:0] temp_c_s8_ff;

   assign q_in = $signed({{2{prod_ff[63]}}, prod_ff[63:21]})
               - $signed({{4{off_c_s7_ff[40]}}, off_c_s7_ff});

   always_ff @(posedge clock) begin
      if (en[7]) begin
         q_ff         <= q_in;
         temp_c_s8_ff <= temp_c_s7_ff;
      end
   end

   // stage 9: final shift and clipping into the output register
   logic [29:0] p_val;
   logic        p_neg, p_big, t_low, t_high;
   logic [14:0] temp_out_ff, temp_out_in;
   logic [17:0] pres_out_ff, pres_out_in;
   logic        flag_ff, flag_in;

   assign p_val  = q_ff[44:15];
   assign p_neg  = p_val[29];
   assign p_big  = !p_neg && (|p_val[28:18]);
   assign t_low  = temp_c_s8_ff[19] && !(&temp_c_s8_ff[18:14]);
   assign t_high = !temp_c_s8_ff[19] && (|temp_c_s8_ff[18:14]);

   always_comb begin
      if (t_low) begin
         temp_out_in = barotc_pkg::TEMP_OUT_MIN;
      end else if (t_high) begin
         temp_out_in = barotc_pkg::TEMP_OUT_MAX;
      end else begin
         temp_out_in = temp_c_s8_ff[14:0];
      end
      if (p_neg) begin
         pres_out_in = '0;
      end else if (p_big) begin
         pres_out_in = barotc_pkg::PRES_OUT_MAX;
      end else begin
         pres_out_in = p_val[17:0];
      end
      flag_in = t_low || t_high || p_neg || p_big;
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         temp_out_ff <= temp_out_in;
         pres_out_ff <= pres_out_in;
         flag_ff     <= flag_in;
      end
   end

   assign rsp_tdata = {7'd0, pres_out_ff, temp_out_ff};
   assign rsp_tuser = flag_ff;

endmodule
